@@ rtl/core/phcs_pkg.sv @@
`default_nettype none

package phcs_pkg;

  // Defaults for the top-level parameters
  localparam int COLUMNS_DEF      = 1024;
  localparam int ROWS_DEF         = 512;
  localparam int NUM_SECTIONS_DEF = 4;
  localparam int COUNT_WIDTH_DEF  = 32;

  // Fixed field widths
  localparam int CUT_W      = 16;
  localparam int SECW_W     = 11;
  localparam int EVT_W      = 32;
  localparam int THR_W      = CUT_W + EVT_W;
  localparam int COORD_W    = 12;
  localparam int HOT_W      = 20;
  localparam int SEC_OUT_W  = 2;
  localparam int REQ_W      = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Request codes
  localparam logic [REQ_W-1:0] REQ_HIT   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_EVAL  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_HOT_CUT       = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SECTION_WIDTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SECTIONED     = 2'd2;

  // Reset values of the configuration registers
  localparam logic [CUT_W-1:0]  HOT_CUT_RST       = 16'd655;
  localparam logic [SECW_W-1:0] SECTION_WIDTH_RST = 11'd256;

  // The threshold product must exceed this before any pixel can be hot
  localparam logic [THR_W-1:0] THR_MIN = 48'd65536;

  typedef struct packed {
    logic clear;
    logic sample;
  } tally_ctl_t;

  function automatic logic [HOT_W-1:0] sat_hot(input logic [31:0] v);
    logic [HOT_W-1:0] r;
    if (v > 32'(20'hFFFFF)) begin
      r = '1;
    end else begin
      r = v[HOT_W-1:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/phcs_map.sv @@
`default_nettype none

module phcs_map #(
  parameter int DEPTH = 524288,
  parameter int AW    = 19,
  parameter int DW    = 32
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/core/phcs_tally.sv @@
`default_nettype none

module phcs_tally #(
  parameter int NUM_SECTIONS = 4,
  parameter int SW           = 3,
  parameter int CW           = 20,
  parameter int DW           = 32
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire phcs_pkg::tally_ctl_t           ctl,
  input  wire logic [SW-1:0]                  sec,
  input  wire logic [DW-1:0]                  q,
  input  wire logic [phcs_pkg::THR_W-1:0]     thr,
  input  wire logic [SW-1:0]                  rd_sec,
  output logic      [CW-1:0]                  total,
  output logic      [CW-1:0]                  sec_count
);

  logic [phcs_pkg::THR_W-1:0] scaled;
  logic                       hot;
  logic [CW-1:0]              per [NUM_SECTIONS];

  // Shared compare: count * 65536 against cut * events
  assign scaled = phcs_pkg::THR_W'({q, 16'h0000});
  assign hot    = scaled > thr;

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      total <= '0;
      for (int i = 0; i < NUM_SECTIONS; i++) begin
        per[i] <= '0;
      end
    end else if (ctl.sample && hot) begin
      total <= total + CW'(1);
      for (int i = 0; i < NUM_SECTIONS; i++) begin
        if (sec == SW'(i)) begin
          per[i] <= per[i] + CW'(1);
        end
      end
    end
  end

  always_comb begin
    sec_count = '0;
    for (int i = 0; i < NUM_SECTIONS; i++) begin
      if (rd_sec == SW'(i)) begin
        sec_count = per[i];
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/pixel_hit_count_hot_pixel_scan_unit.sv @@
// Hit: accept with map read, then write back in ST_HIT_WR; next item may start right after.
// Evaluate: ST_EVAL_MUL, ST_EVAL_CHK, the pixel scan and ST_DRAIN (the last two skipped
//   when cut*events <= 65536), then up to NUM_SECTIONS+1 result words; each strobes for one cycle.
// Clear: every map entry is zeroed, one per cycle through the single write port.
// Reset: synchronous; afterwards a clearing pass over the whole map runs with busy high.
// Results cannot be stalled by the receiver.
`default_nettype none

module pixel_hit_count_hot_pixel_scan_unit #(
  parameter int COLUMNS      = phcs_pkg::COLUMNS_DEF,
  parameter int ROWS         = phcs_pkg::ROWS_DEF,
  parameter int NUM_SECTIONS = phcs_pkg::NUM_SECTIONS_DEF,
  parameter int COUNT_WIDTH  = phcs_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  output logic                                   busy,
  input  wire logic [phcs_pkg::REQ_W-1:0]        req_type,
  input  wire logic [phcs_pkg::COORD_W-1:0]      pixel_x,
  input  wire logic [phcs_pkg::COORD_W-1:0]      pixel_y,
  input  wire logic [phcs_pkg::EVT_W-1:0]        event_count,
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic [phcs_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [phcs_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                                   result_valid,
  output logic                                   result_kind,
  output logic      [phcs_pkg::SEC_OUT_W-1:0]    section_index,
  output logic      [phcs_pkg::HOT_W-1:0]        hot_count,
  output logic                                   last
);

  localparam int NPIX = COLUMNS * ROWS;
  localparam int AW   = (NPIX > 1) ? $clog2(NPIX) : 1;
  localparam int XW   = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int YW   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int SW   = $clog2(NUM_SECTIONS + 1);
  localparam int CW   = $clog2(NPIX + 1);
  localparam int LW   = 2 * phcs_pkg::COORD_W;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_HIT_WR,
    ST_EVAL_MUL,
    ST_EVAL_CHK,
    ST_SCAN,
    ST_DRAIN,
    ST_EMIT
  } state_t;

  state_t                          state;
  logic [phcs_pkg::CUT_W-1:0]      hot_cut;
  logic [phcs_pkg::SECW_W-1:0]     section_width;
  logic                            sectioned;
  logic [AW-1:0]                   addr;
  logic [AW-1:0]                   hit_addr;
  logic [XW-1:0]                   x;
  logic [YW-1:0]                   y;
  logic [phcs_pkg::SECW_W-1:0]     colpos;
  logic [SW-1:0]                   sec;
  logic [SW-1:0]                   emit_idx;
  logic [phcs_pkg::EVT_W-1:0]      events;
  logic [phcs_pkg::THR_W-1:0]      thr;
  logic                            rd_valid;
  logic [SW-1:0]                   rd_sec;

  logic                            in_range;
  logic [LW-1:0]                   hit_lin;
  logic                            map_we;
  logic [AW-1:0]                   map_waddr;
  logic [COUNT_WIDTH-1:0]          map_wdata;
  logic [AW-1:0]                   map_raddr;
  logic [COUNT_WIDTH-1:0]          map_q;
  logic [COUNT_WIDTH-1:0]          inc;
  logic [CW-1:0]                   total;
  logic [CW-1:0]                   sec_count;
  phcs_pkg::tally_ctl_t            tally_ctl;

  assign busy      = (state != ST_IDLE);
  // take register writes only between items
  assign cfg_ready = !busy;

  assign in_range = ({1'b0, pixel_x} < (phcs_pkg::COORD_W + 1)'(COLUMNS)) &&
                    ({1'b0, pixel_y} < (phcs_pkg::COORD_W + 1)'(ROWS));
  assign hit_lin  = LW'(pixel_x) * LW'(ROWS) + LW'(pixel_y);

  // Saturating increment of the counter read back for a hit
  assign inc = (map_q == '1) ? map_q : map_q + COUNT_WIDTH'(1);

  assign map_we    = (state == ST_CLEAR) || (state == ST_HIT_WR);
  assign map_waddr = (state == ST_CLEAR) ? addr : hit_addr;
  assign map_wdata = (state == ST_CLEAR) ? '0 : inc;
  assign map_raddr = (state == ST_IDLE) ? hit_lin[AW-1:0] : addr;

  assign tally_ctl.clear  = (state == ST_EVAL_MUL);
  assign tally_ctl.sample = rd_valid;

  phcs_map #(
    .DEPTH (NPIX),
    .AW    (AW),
    .DW    (COUNT_WIDTH)
  ) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .raddr (map_raddr),
    .rdata (map_q)
  );

  phcs_tally #(
    .NUM_SECTIONS (NUM_SECTIONS),
    .SW           (SW),
    .CW           (CW),
    .DW           (COUNT_WIDTH)
  ) u_tally (
    .clk       (clk),
    .rst       (rst),
    .ctl       (tally_ctl),
    .sec       (rd_sec),
    .q         (map_q),
    .thr       (thr),
    .rd_sec    (emit_idx),
    .total     (total),
    .sec_count (sec_count)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_CLEAR;
      addr          <= '0;
      rd_valid      <= 1'b0;
      result_valid  <= 1'b0;
      hot_cut       <= phcs_pkg::HOT_CUT_RST;
      section_width <= phcs_pkg::SECTION_WIDTH_RST;
      sectioned     <= 1'b0;
    end else begin
      result_valid <= 1'b0;
      rd_valid     <= 1'b0;

      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          phcs_pkg::CFG_HOT_CUT:       hot_cut       <= cfg_data[phcs_pkg::CUT_W-1:0];
          phcs_pkg::CFG_SECTION_WIDTH: section_width <= cfg_data[phcs_pkg::SECW_W-1:0];
          phcs_pkg::CFG_SECTIONED:     sectioned     <= cfg_data[0];
          default: ;
        endcase
      end

      case (state)
        ST_CLEAR: begin
          if (addr == AW'(NPIX - 1)) begin
            addr  <= '0;
            state <= ST_IDLE;
          end else begin
            addr <= addr + AW'(1);
          end
        end
        ST_IDLE: begin
          if (start) begin
            case (req_type)
              phcs_pkg::REQ_HIT: begin
                if (in_range) begin
                  hit_addr <= hit_lin[AW-1:0];
                  state    <= ST_HIT_WR;
                end
              end
              phcs_pkg::REQ_EVAL: begin
                events <= event_count;
                state  <= ST_EVAL_MUL;
              end
              phcs_pkg::REQ_CLEAR: begin
                addr  <= '0;
                state <= ST_CLEAR;
              end
              default: ;
            endcase
          end
        end
        ST_HIT_WR: begin
          state <= ST_IDLE;
        end
        ST_EVAL_MUL: begin
          thr   <= phcs_pkg::THR_W'(hot_cut) * phcs_pkg::THR_W'(events);
          state <= ST_EVAL_CHK;
        end
        ST_EVAL_CHK: begin
          addr     <= '0;
          x        <= '0;
          y        <= '0;
          colpos   <= '0;
          emit_idx <= '0;
          sec      <= (section_width == '0) ? SW'(NUM_SECTIONS) : '0;
          state    <= (thr > phcs_pkg::THR_MIN) ? ST_SCAN : ST_EMIT;
        end
        ST_SCAN: begin
          rd_valid <= 1'b1;
          rd_sec   <= sec;
          addr     <= addr + AW'(1);
          if (y == YW'(ROWS - 1)) begin
            y <= '0;
            x <= x + XW'(1);
            // advance the section once its column span is used up
            if (({1'b0, colpos} + 12'd1) == {1'b0, section_width}) begin
              colpos <= '0;
              if (sec != SW'(NUM_SECTIONS)) begin
                sec <= sec + SW'(1);
              end
            end else begin
              colpos <= colpos + phcs_pkg::SECW_W'(1);
            end
            if (x == XW'(COLUMNS - 1)) begin
              state <= ST_DRAIN;
            end
          end else begin
            y <= y + YW'(1);
          end
        end
        ST_DRAIN: begin
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          if (sectioned && (emit_idx != SW'(NUM_SECTIONS))) begin
            if (sec_count != '0) begin
              result_valid  <= 1'b1;
              result_kind   <= 1'b0;
              section_index <= phcs_pkg::SEC_OUT_W'(emit_idx);
              hot_count     <= phcs_pkg::sat_hot(32'(sec_count));
              last          <= 1'b0;
            end
            emit_idx <= emit_idx + SW'(1);
          end else begin
            result_valid  <= 1'b1;
            result_kind   <= 1'b1;
            section_index <= '0;
            hot_count     <= phcs_pkg::sat_hot(32'(total));
            last          <= 1'b1;
            state         <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/phcs_checker.sv @@
`default_nettype none

module phcs_checker (
  input wire logic                          clk,
  input wire logic                          rst,
  input wire logic                          start,
  input wire logic                          busy,
  input wire logic [phcs_pkg::REQ_W-1:0]    req_type,
  input wire logic                          result_valid,
  input wire logic                          result_kind,
  input wire logic                          last
);

  // The map is swept clean after every reset
  a_clear_after_reset: assert property (@(posedge clk) rst |=> busy)
    else $error("block not busy with clearing pass after reset");

  // The total is the one and only final word
  a_total_is_last: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result_kind == last))
    else $error("result kind and last flag disagree");

  // A section word is always followed by more work
  a_section_while_busy: assert property (@(posedge clk) disable iff (rst)
    (result_valid && !last) |-> busy)
    else $error("section word shown while block idle");

  // An accepted evaluate keeps the block busy
  a_eval_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (req_type == phcs_pkg::REQ_EVAL)) |=> busy)
    else $error("evaluate accepted but block not busy");

  // No result word appears right after an idle cycle without a request
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    (!busy && !start) |=> !result_valid)
    else $error("result word without a pending evaluate");

endmodule

bind pixel_hit_count_hot_pixel_scan_unit phcs_checker u_phcs_checker (.*);

`default_nettype wire
